@@ hdl/pdra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pdra_pkg;

  localparam int DEST_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 6;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_PLACED   = 2'd0,
    KIND_SENT     = 2'd1,
    KIND_DROPPED  = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SCAN    = 3'd1,
    S_PLACE   = 3'd2,
    S_SEND_RD = 3'd3,
    S_SEND    = 3'd4
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [DEST_W-1:0]   dest_addr;
    logic [HANDLE_W-1:0] record_handle;
  } cmd_t;

  typedef struct packed {
    kind_e               kind;
    logic [DEST_W-1:0]   dest_addr_out;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    record_count;
    logic [HANDLE_W-1:0] handle_out;
    logic                last;
  } result_t;

  typedef struct packed {
    logic pop;
    logic push;
  } free_ctrl_t;

  typedef struct packed {
    logic append;
    logic unlink;
  } list_ctrl_t;

  typedef struct packed {
    logic wr;
    logic set_busy;
    logic clr_busy;
  } ent_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/pdra_entry_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdra_entry_store import pdra_pkg::*; #(
  parameter int NUM_ENTRIES       = 16,
  parameter int RECORDS_PER_FRAME = 46
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ent_ctrl_t                       ctrl_i,
  input  wire logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] rd_idx_i,
  input  wire logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] wr_idx_i,
  input  wire logic [DEST_W-1:0]               wr_dest_i,
  input  wire logic [$clog2(RECORDS_PER_FRAME + 1)-1:0] wr_cnt_i,
  output logic [DEST_W-1:0]                    rd_dest_o,
  output logic [$clog2(RECORDS_PER_FRAME + 1)-1:0] rd_cnt_o,
  output logic                                 rd_busy_o
);

  localparam int CW = $clog2(RECORDS_PER_FRAME + 1);

  logic [DEST_W+CW-1:0]   mem [NUM_ENTRIES];
  logic [DEST_W+CW-1:0]   rd_q;
  logic                   rd_busy_q;
  logic [NUM_ENTRIES-1:0] busy_q;
  logic [NUM_ENTRIES-1:0] busy_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[wr_idx_i] <= {wr_dest_i, wr_cnt_i};
    end
    rd_q <= mem[rd_idx_i];
  end

  always_comb begin
    busy_d = busy_q;
    if (ctrl_i.set_busy) begin
      busy_d[wr_idx_i] = 1'b1;
    end
    if (ctrl_i.clr_busy) begin
      busy_d[wr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      rd_busy_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      rd_busy_q <= busy_q[rd_idx_i];
    end
  end

  assign rd_dest_o = rd_q[DEST_W+CW-1:CW];
  assign rd_cnt_o  = rd_q[CW-1:0];
  assign rd_busy_o = rd_busy_q;

endmodule

`default_nettype wire

@@ hdl/pdra_free_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdra_free_fifo import pdra_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire free_ctrl_t ctrl_i,
  input  wire logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] push_idx_i,
  output logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] head_idx_o,
  output logic [$clog2(NUM_ENTRIES + 1)-1:0] count_o
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(NUM_ENTRIES - 1);
  localparam logic [LW-1:0] FULL_CNT = LW'(NUM_ENTRIES);

  logic [IW-1:0] mem [NUM_ENTRIES];
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [LW-1:0] count_q, count_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [IW-1:0] rd_mem_q;
  logic [IW-1:0] rd_init_q;
  logic          rd_virt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_idx_i;
    end
    rd_mem_q  <= mem[head_q];
    rd_init_q <= LAST_POS - head_q;
    rd_virt_q <= LW'(head_q) >= fill_q;
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    fill_d  = fill_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
      if (fill_q != FULL_CNT) begin
        fill_d = fill_q + 1'b1;
      end
    end
    case ({ctrl_i.push, ctrl_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= FULL_CNT;
      fill_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  assign head_idx_o = rd_virt_q ? rd_init_q : rd_mem_q;
  assign count_o    = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (count_q != FULL_CNT) || ctrl_i.pop)
    else $error("free list push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_q != '0)
    else $error("free list pop while empty");

endmodule

`default_nettype wire

@@ hdl/pdra_order_list.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdra_order_list import pdra_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire list_ctrl_t ctrl_i,
  input  wire logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] idx_i,
  output logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] head_o,
  output logic [$clog2(NUM_ENTRIES + 1)-1:0] len_o
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_ENTRIES + 1);

  logic [IW-1:0] next_mem [NUM_ENTRIES];
  logic [IW-1:0] prev_mem [NUM_ENTRIES];
  logic [IW-1:0] next_rd_q;
  logic [IW-1:0] prev_rd_q;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [LW-1:0] len_q, len_d;

  logic          next_we;
  logic [IW-1:0] next_wa;
  logic [IW-1:0] next_wd;
  logic          prev_we;
  logic [IW-1:0] prev_wa;
  logic [IW-1:0] prev_wd;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    len_d   = len_q;
    next_we = 1'b0;
    next_wa = prev_rd_q;
    next_wd = next_rd_q;
    prev_we = 1'b0;
    prev_wa = next_rd_q;
    prev_wd = prev_rd_q;
    if (ctrl_i.append) begin
      if (len_q == '0) begin
        head_d = idx_i;
      end else begin
        next_we = 1'b1;
        next_wa = tail_q;
        next_wd = idx_i;
      end
      prev_we = 1'b1;
      prev_wa = idx_i;
      prev_wd = tail_q;
      tail_d  = idx_i;
      len_d   = len_q + 1'b1;
    end else if (ctrl_i.unlink) begin
      if (idx_i == head_q) begin
        head_d = next_rd_q;
      end else begin
        next_we = 1'b1;
      end
      if (idx_i == tail_q) begin
        tail_d = prev_rd_q;
      end else begin
        prev_we = 1'b1;
      end
      len_d = len_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    next_rd_q <= next_mem[idx_i];
    prev_rd_q <= prev_mem[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      len_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      len_q  <= len_d;
    end
  end

  assign head_o = head_q;
  assign len_o  = len_q;

  a_unlink_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.unlink |-> len_q != '0)
    else $error("unlink from empty pending order");

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.append && ctrl_i.unlink))
    else $error("append and unlink in one cycle");

endmodule

`default_nettype wire

@@ hdl/per_destination_record_aggregator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Per-destination record aggregator.
// Command channel: cmd_i is taken at a rising edge with start high and busy
// low. An add item places one record in the open frame of its destination,
// opening a frame from the free list when there is none (or dropping it if the
// list is empty); a flush item sends every pending frame, oldest first.
// Result channel: each result sits on result_o for exactly one cycle, marked
// by result_valid_o; the receiver cannot stall it. last marks the final
// result of an item.
// A zero-destination add answers in the cycle after it is taken. Any other
// add scans the destination memory one entry per cycle, stopping early on a
// match, and registers its placed result from S_PLACE; a full frame then adds
// its sent result, read in S_SEND_RD and sent from S_SEND. A flush sends its
// frames in turn, each through S_SEND_RD and S_SEND. The block takes one item
// at a time; busy stays high until the item's last result is registered.
// Reset: pending order empty, free list full in descending index order.
// The memories need no clearing pass: free-list entries never written since
// reset read their reset order, and entry data is read only once written.
module per_destination_record_aggregator_top import pdra_pkg::*; #(
  parameter int NUM_ENTRIES       = 16,
  parameter int RECORDS_PER_FRAME = 46
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd_i,
  output logic         result_valid_o,
  output result_t      result_o
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam int CW = $clog2(RECORDS_PER_FRAME + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_ENTRIES - 1);
  localparam logic [CW-1:0] REC_LIMIT = CW'(RECORDS_PER_FRAME);

  state_e  state_q, state_d;
  cmd_t    cmd_q, cmd_d;
  logic [IW-1:0] scan_idx_q, scan_idx_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [CW-1:0] hit_cnt_q, hit_cnt_d;
  logic [IW-1:0] cur_e_q, cur_e_d;
  result_t result_q, result_d;
  logic    result_valid_q, result_valid_d;

  ent_ctrl_t  ent_ctrl;
  free_ctrl_t free_ctrl;
  list_ctrl_t list_ctrl;
  logic [IW-1:0]     ent_rd_idx;
  logic [IW-1:0]     ent_wr_idx;
  logic [CW-1:0]     ent_wr_cnt;
  logic [DEST_W-1:0] ent_rd_dest;
  logic [CW-1:0]     ent_rd_cnt;
  logic              ent_rd_busy;
  logic [IW-1:0]     free_head;
  logic [LW-1:0]     free_cnt;
  logic [IW-1:0]     list_idx;
  logic [IW-1:0]     list_head;
  logic [LW-1:0]     list_len;

  logic          accept;
  logic          match;
  logic          scan_done;
  logic          free_empty;
  logic          flush_mode;
  logic [IW-1:0] place_idx;
  logic [CW-1:0] place_cnt;
  logic [CW-1:0] cnt_inc;
  logic          frame_full;
  logic [IW-1:0] send_addr;
  logic [IW+SLOT_W-1:0] place_slot_ext;
  logic [IW+SLOT_W-1:0] send_slot_ext;
  logic [CW+POS_W-1:0]  place_pos_ext;
  logic [CW+POS_W-1:0]  send_cnt_ext;

  assign accept     = start && (state_q == S_IDLE);
  assign match      = cmp_vld_q && ent_rd_busy && (ent_rd_dest == cmd_q.dest_addr);
  assign scan_done  = cmp_vld_q && (cmp_idx_q == LAST_IDX);
  assign free_empty = (free_cnt == '0);
  assign flush_mode = (cmd_q.op == OP_FLUSH);
  assign place_idx  = hit_q ? hit_idx_q : free_head;
  assign place_cnt  = hit_q ? hit_cnt_q : '0;
  assign cnt_inc    = place_cnt + 1'b1;
  assign frame_full = (cnt_inc >= REC_LIMIT);
  assign send_addr  = flush_mode ? list_head : cur_e_q;

  assign place_slot_ext = {{SLOT_W{1'b0}}, place_idx};
  assign send_slot_ext  = {{SLOT_W{1'b0}}, cur_e_q};
  assign place_pos_ext  = {{POS_W{1'b0}}, place_cnt};
  assign send_cnt_ext   = {{POS_W{1'b0}}, ent_rd_cnt};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i.op == OP_FLUSH) begin
            state_d = (list_len != '0) ? S_SEND_RD : S_IDLE;
          end else if (cmd_i.dest_addr != '0) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match || scan_done) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (!hit_q && free_empty) begin
          state_d = S_IDLE;
        end else if (frame_full) begin
          state_d = S_SEND_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SEND_RD: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (flush_mode && (list_len != LW'(1))) begin
          state_d = S_SEND_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_d          = cmd_q;
    scan_idx_d     = scan_idx_q;
    cmp_idx_d      = scan_idx_q;
    cmp_vld_d      = (state_q == S_SCAN);
    hit_d          = hit_q;
    hit_idx_d      = hit_idx_q;
    hit_cnt_d      = hit_cnt_q;
    cur_e_d        = cur_e_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    ent_ctrl       = '0;
    free_ctrl      = '0;
    list_ctrl      = '0;
    ent_rd_idx     = scan_idx_q;
    ent_wr_idx     = cur_e_q;
    ent_wr_cnt     = cnt_inc;
    list_idx       = cur_e_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d      = cmd_i;
          scan_idx_d = '0;
          hit_d      = 1'b0;
          if ((cmd_i.op == OP_ADD) && (cmd_i.dest_addr == '0)) begin
            result_valid_d         = 1'b1;
            result_d.kind          = KIND_REJECTED;
            result_d.dest_addr_out = '0;
            result_d.slot          = '0;
            result_d.position      = '0;
            result_d.record_count  = '0;
            result_d.handle_out    = cmd_i.record_handle;
            result_d.last          = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_q != LAST_IDX) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_cnt_d = ent_rd_cnt;
        end
      end
      S_PLACE: begin
        result_valid_d         = 1'b1;
        result_d.dest_addr_out = cmd_q.dest_addr;
        result_d.record_count  = '0;
        result_d.handle_out    = cmd_q.record_handle;
        if (!hit_q && free_empty) begin
          result_d.kind     = KIND_DROPPED;
          result_d.slot     = '0;
          result_d.position = '0;
          result_d.last     = 1'b1;
        end else begin
          free_ctrl.pop    = !hit_q;
          list_ctrl.append = !hit_q;
          list_idx         = place_idx;
          ent_ctrl.wr       = 1'b1;
          ent_ctrl.set_busy = !hit_q;
          ent_wr_idx        = place_idx;
          cur_e_d           = place_idx;
          result_d.kind     = KIND_PLACED;
          result_d.slot     = place_slot_ext[SLOT_W-1:0];
          result_d.position = place_pos_ext[POS_W-1:0];
          result_d.last     = !frame_full;
        end
      end
      S_SEND_RD: begin
        ent_rd_idx = send_addr;
        list_idx   = send_addr;
        cur_e_d    = send_addr;
      end
      S_SEND: begin
        list_ctrl.unlink       = 1'b1;
        free_ctrl.push         = 1'b1;
        ent_ctrl.clr_busy      = 1'b1;
        result_valid_d         = 1'b1;
        result_d.kind          = KIND_SENT;
        result_d.dest_addr_out = ent_rd_dest;
        result_d.slot          = send_slot_ext[SLOT_W-1:0];
        result_d.position      = '0;
        result_d.record_count  = send_cnt_ext[POS_W-1:0];
        result_d.handle_out    = '0;
        result_d.last          = !flush_mode || (list_len == LW'(1));
      end
      default: begin
        result_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmp_vld_q      <= 1'b0;
      hit_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cmp_vld_q      <= cmp_vld_d;
      hit_q          <= hit_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    cur_e_q    <= cur_e_d;
    result_q   <= result_d;
  end

  pdra_entry_store #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .RECORDS_PER_FRAME(RECORDS_PER_FRAME)
  ) u_entry_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ent_ctrl),
    .rd_idx_i (ent_rd_idx),
    .wr_idx_i (ent_wr_idx),
    .wr_dest_i(cmd_q.dest_addr),
    .wr_cnt_i (ent_wr_cnt),
    .rd_dest_o(ent_rd_dest),
    .rd_cnt_o (ent_rd_cnt),
    .rd_busy_o(ent_rd_busy)
  );

  pdra_free_fifo #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_free_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (free_ctrl),
    .push_idx_i(cur_e_q),
    .head_idx_o(free_head),
    .count_o   (free_cnt)
  );

  pdra_order_list #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_order_list (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(list_ctrl),
    .idx_i (list_idx),
    .head_o(list_head),
    .len_o (list_len)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_entries_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((LW+1)'(free_cnt) + (LW+1)'(list_len)) == (LW+1)'(NUM_ENTRIES))
    else $error("free and pending entries do not add up");

  a_send_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND) |-> (list_len != '0))
    else $error("frame send with empty pending order");

endmodule

`default_nettype wire

@@ test/record_aggregator_checker.sv @@
`timescale 1ns / 1ps

module record_aggregator_checker import pdra_pkg::*; #(
  parameter int NUM_ENTRIES       = 16,
  parameter int RECORDS_PER_FRAME = 46
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    busy_i,
  input  wire cmd_t    cmd_i,
  input  wire logic    result_valid_i,
  input  wire result_t result_i,
  output int           fail_count_o,
  output int           pending_o
);

  logic [DEST_W-1:0] entry_dest [NUM_ENTRIES];
  int unsigned       entry_fill [NUM_ENTRIES];
  int unsigned       open_order[$];
  int unsigned       free_list[$];
  result_t           frames_due[$];
  int                mismatches = 0;

  function automatic result_t make_result(kind_e kind, logic [DEST_W-1:0] dest,
                                          int unsigned slot, int unsigned pos,
                                          int unsigned cnt, logic [HANDLE_W-1:0] handle);
    result_t r;
    r.kind          = kind;
    r.dest_addr_out = dest;
    r.slot          = slot[SLOT_W-1:0];
    r.position      = pos[POS_W-1:0];
    r.record_count  = cnt[POS_W-1:0];
    r.handle_out    = handle;
    r.last          = 1'b0;
    return r;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      entry_dest[i] = '0;
      entry_fill[i] = 0;
    end
    open_order.delete();
    free_list.delete();
    for (int i = 0; i < NUM_ENTRIES; i++) free_list.push_back(NUM_ENTRIES - 1 - i);
    frames_due.delete();
  endtask

  task automatic ship_frame(int unsigned pos);
    int unsigned e;
    e = open_order[pos];
    frames_due.push_back(make_result(KIND_SENT, entry_dest[e], e, 0, entry_fill[e], '0));
    open_order.delete(pos);
    entry_fill[e] = 0;
    free_list.push_back(e);
  endtask

  task automatic predict_item(cmd_t c);
    int          hit;
    int unsigned e;
    int unsigned depth_before;
    result_t     r;
    hit          = -1;
    depth_before = frames_due.size();
    if (c.op == OP_FLUSH) begin
      while (open_order.size() > 0) ship_frame(0);
    end else if (c.dest_addr == '0) begin
      frames_due.push_back(make_result(KIND_REJECTED, '0, 0, 0, 0, c.record_handle));
    end else begin
      foreach (open_order[i])
        if (hit < 0 && entry_dest[open_order[i]] == c.dest_addr) hit = i;
      if (hit < 0 && free_list.size() == 0) begin
        frames_due.push_back(make_result(KIND_DROPPED, c.dest_addr, 0, 0, 0,
                                         c.record_handle));
      end else begin
        if (hit < 0) begin
          e = free_list.pop_front();
          entry_dest[e] = c.dest_addr;
          entry_fill[e] = 0;
          open_order.push_back(e);
          hit = open_order.size() - 1;
        end
        e = open_order[hit];
        frames_due.push_back(make_result(KIND_PLACED, c.dest_addr, e, entry_fill[e], 0,
                                         c.record_handle));
        entry_fill[e]++;
        if (entry_fill[e] >= RECORDS_PER_FRAME) ship_frame(hit);
      end
    end
    if (frames_due.size() > depth_before) begin
      r = frames_due.pop_back();
      r.last = 1'b1;
      frames_due.push_back(r);
    end
  endtask

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s expected %h got %h", $time, name, want, got);
    return 1'b0;
  endfunction

  task automatic check_result(result_t got);
    result_t want;
    bit      ok;
    if (frames_due.size() == 0) begin
      $display("%0t: result expected none got %h", $time, got);
      mismatches++;
    end else begin
      want = frames_due.pop_front();
      ok = field_ok("kind", 32'(want.kind), 32'(got.kind))
         & field_ok("dest_addr_out", want.dest_addr_out, got.dest_addr_out)
         & field_ok("slot", 32'(want.slot), 32'(got.slot))
         & field_ok("position", 32'(want.position), 32'(got.position))
         & field_ok("record_count", 32'(want.record_count), 32'(got.record_count))
         & field_ok("handle_out", 32'(want.handle_out), 32'(got.handle_out))
         & field_ok("last", 32'(want.last), 32'(got.last));
      if (!ok) mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_tables();
    end else begin
      if (result_valid_i) check_result(result_i);
      if (start_i && !busy_i) predict_item(cmd_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= frames_due.size();
  end

endmodule

@@ test/per_destination_record_aggregator_top_test.sv @@
`timescale 1ns / 1ps

module per_destination_record_aggregator_top_test;
  import pdra_pkg::*;

  localparam int NUM_ENTRIES       = 16;
  localparam int RECORDS_PER_FRAME = 46;
  localparam int RANDOM_ITEMS      = 92;
  localparam int QUIET_ITEMS       = 30;
  localparam int POOL_SIZE         = 6;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  cmd_t    cmd_i  = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;
  int      fail_count;
  int      pending;

  logic [DEST_W-1:0] dest_pool [POOL_SIZE];
  int                items_sent = 0;
  bit                quiet      = 1'b0;

  always #5 clk_i = ~clk_i;

  per_destination_record_aggregator_top #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .RECORDS_PER_FRAME(RECORDS_PER_FRAME)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  record_aggregator_checker #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .RECORDS_PER_FRAME(RECORDS_PER_FRAME)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .cmd_i         (cmd_i),
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic send_cmd(op_e op, logic [DEST_W-1:0] dest, logic [HANDLE_W-1:0] handle);
    @(negedge clk_i);
    start               = 1'b1;
    cmd_i.op            = op;
    cmd_i.dest_addr     = dest;
    cmd_i.record_handle = handle;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
  endtask

  task automatic add_record(logic [DEST_W-1:0] dest);
    send_cmd(OP_ADD, dest, 16'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int random_base;
    int pick;
    int burst;
    logic [DEST_W-1:0] dest;

    foreach (dest_pool[i]) begin
      do dest_pool[i] = $urandom(); while (dest_pool[i] == '0);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_cmd(OP_FLUSH, '1, '1);
    send_cmd(OP_ADD, '0, 16'hFFFF);
    send_cmd(OP_ADD, '0, 16'h0000);
    send_cmd(OP_ADD, 32'hFFFF_FFFF, 16'h0000);
    send_cmd(OP_ADD, 32'h0000_0001, 16'hFFFF);
    send_cmd(OP_ADD, 32'hFFFF_FFFF, 16'h8000);
    send_cmd(OP_FLUSH, '0, '0);
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_cmd(OP_ADD, 32'h0000_0100 << i, 16'h5A5A ^ i[15:0]);
    send_cmd(OP_ADD, 32'hA5A5_5A5A, 16'h1234);
    send_cmd(OP_ADD, 32'h0000_0100, 16'h4321);
    send_cmd(OP_FLUSH, 32'h5555_AAAA, 16'hAAAA);
    drain();

    random_base = items_sent;
    add_record(dest_pool[0]);
    add_record(dest_pool[1]);
    add_record(dest_pool[2]);
    repeat (RECORDS_PER_FRAME - 1) add_record(dest_pool[1]);

    while (items_sent - random_base < RANDOM_ITEMS) begin
      quiet = (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 15);
      if (pick == 0) begin
        if (!quiet && $urandom_range(0, 1) == 0) drain();
        send_cmd(OP_FLUSH, $urandom(), 16'($urandom_range(0, 65535)));
      end else if (pick == 1) begin
        add_record('0);
      end else if (pick <= 3) begin
        dest = $urandom();
        add_record(dest);
      end else begin
        burst = $urandom_range(1, 6);
        dest  = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
        repeat (burst) add_record(dest);
      end
    end
    send_cmd(OP_FLUSH, $urandom(), 16'($urandom_range(0, 65535)));

    drain();
    repeat (3 * NUM_ENTRIES + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("per_destination_record_aggregator_top_test OK");
    end else begin
      $display("per_destination_record_aggregator_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("per_destination_record_aggregator_top_test NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pdra_pkg.sv
hdl/pdra_entry_store.sv
hdl/pdra_free_fifo.sv
hdl/pdra_order_list.sv
hdl/per_destination_record_aggregator_top.sv
test/record_aggregator_checker.sv
test/per_destination_record_aggregator_top_test.sv
